// ===== rtl/core/ultrasonic_frame_parser_unit_macros.svh =====
// ============================================================================
// Ultrasonic frame parser assertion macros
// Shared concurrent assertion forms for the parser blocks. Each macro expects
// clk and rst to be visible where it is used.
// ============================================================================
`ifndef ULTRASONIC_FRAME_PARSER_UNIT_MACROS_SVH
`define ULTRASONIC_FRAME_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ufp_pkg.sv =====
// ============================================================================
// Ultrasonic frame parser package
// Shared types, codes and sizing constants for the frame parser blocks.
// ============================================================================
package ufp_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int DATA_BYTES   = 2 * SENSOR_COUNT;
  localparam int OUT_LANES    = 4;
  localparam int ASM_IDX_W    = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  localparam logic [3:0]  POS_HUNT      = 4'd0;
  localparam logic [3:0]  POS_FIRST     = 4'd1;
  localparam logic [3:0]  POS_LAST_DATA = 4'(DATA_BYTES);
  localparam logic [15:0] STALE_VALUE   = 16'hFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_CSUM  = 2'd1,
    ST_SHORT = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } ufp_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] distance_0;
    logic [15:0] distance_1;
    logic [15:0] distance_2;
    logic [15:0] distance_3;
  } ufp_out_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] stale_limit_ticks;
    logic [7:0]  gap_limit_ticks;
  } ufp_cfg_t;

endpackage

// ===== rtl/core/ufp_cfg_regs.sv =====
// ============================================================================
// Ultrasonic frame parser configuration registers
// Holds the start byte, the stale limit and the byte gap limit.
// ============================================================================
module ufp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ufp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ufp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ufp_pkg::ufp_cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte        <= 8'd255;
      cfg.stale_limit_ticks <= 16'd500;
      cfg.gap_limit_ticks   <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ufp_pkg::REG_START_BYTE:  cfg.start_byte        <= cfg_data[7:0];
        ufp_pkg::REG_STALE_LIMIT: cfg.stale_limit_ticks <= cfg_data;
        ufp_pkg::REG_GAP_LIMIT:   cfg.gap_limit_ticks   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ufp_frame_engine.sv =====
// ============================================================================
// Ultrasonic frame parser engine
// Frame state, checksum, gap and age timing, and result formation for one
// registered item per cycle while go is high.
// ============================================================================
module ufp_frame_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  ufp_pkg::ufp_in_t     item,
  input  ufp_pkg::ufp_cfg_t    cfg,
  output logic                 res_valid,
  output ufp_pkg::ufp_out_t    res
);

  logic [3:0]  frame_position;
  logic [7:0]  running_sum;
  logic [15:0] frame_age;
  logic [7:0]  byte_gap;
  logic        stale_flag;
  logic [7:0]  assembly_bytes [ufp_pkg::DATA_BYTES];
  logic [15:0] stored_distances [ufp_pkg::SENSOR_COUNT];

  logic [3:0]  frame_position_next;
  logic [7:0]  running_sum_next;
  logic [15:0] frame_age_next;
  logic [7:0]  byte_gap_next;
  logic        stale_flag_next;
  logic [15:0] age_inc;
  logic [7:0]  gap_inc;
  logic        asm_we;
  logic [ufp_pkg::ASM_IDX_W-1:0] asm_idx;
  logic        load_dist;
  logic        emit;
  ufp_pkg::status_t status;
  logic [15:0] new_dist [ufp_pkg::SENSOR_COUNT];
  logic [15:0] dist_out [ufp_pkg::OUT_LANES];

  assign age_inc = (frame_age == 16'hFFFF) ? frame_age : frame_age + 16'd1;
  assign gap_inc = (byte_gap == 8'hFF) ? byte_gap : byte_gap + 8'd1;
  assign asm_idx = ufp_pkg::ASM_IDX_W'(frame_position - 4'd1);

  always_comb begin
    frame_position_next = frame_position;
    running_sum_next    = running_sum;
    frame_age_next      = frame_age;
    byte_gap_next       = byte_gap;
    stale_flag_next     = stale_flag;
    asm_we              = 1'b0;
    load_dist           = 1'b0;
    emit                = 1'b0;
    status              = ufp_pkg::ST_GOOD;
    if (item.operation == ufp_pkg::OP_BYTE) begin
      byte_gap_next = '0;
      if (frame_position == ufp_pkg::POS_HUNT) begin
        if (item.rx_byte == cfg.start_byte) begin
          frame_position_next = ufp_pkg::POS_FIRST;
          running_sum_next    = item.rx_byte;
        end
      end else if (frame_position <= ufp_pkg::POS_LAST_DATA) begin
        asm_we              = 1'b1;
        running_sum_next    = running_sum + item.rx_byte;
        frame_position_next = frame_position + 4'd1;
      end else begin
        frame_position_next = ufp_pkg::POS_HUNT;
        emit                = 1'b1;
        if (item.rx_byte != running_sum) begin
          status = ufp_pkg::ST_CSUM;
        end else begin
          status          = ufp_pkg::ST_GOOD;
          load_dist       = 1'b1;
          frame_age_next  = '0;
          stale_flag_next = 1'b0;
        end
      end
    end else begin
      frame_age_next = age_inc;
      if (frame_position != ufp_pkg::POS_HUNT && gap_inc > cfg.gap_limit_ticks) begin
        frame_position_next = ufp_pkg::POS_HUNT;
        byte_gap_next       = '0;
        emit                = 1'b1;
        status              = ufp_pkg::ST_SHORT;
      end else begin
        if (frame_position != ufp_pkg::POS_HUNT) begin
          byte_gap_next = gap_inc;
        end
        if (!stale_flag && age_inc >= cfg.stale_limit_ticks) begin
          stale_flag_next = 1'b1;
          emit            = 1'b1;
          status          = ufp_pkg::ST_STALE;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < ufp_pkg::SENSOR_COUNT; j++) begin
      new_dist[j] = {assembly_bytes[ufp_pkg::ASM_IDX_W'(2 * j)],
                     assembly_bytes[ufp_pkg::ASM_IDX_W'(2 * j + 1)]};
    end
  end

  for (genvar j = 0; j < ufp_pkg::OUT_LANES; j++) begin : g_lane
    if (j < ufp_pkg::SENSOR_COUNT) begin : g_used
      assign dist_out[j] = load_dist ? new_dist[j] :
                           (status == ufp_pkg::ST_STALE || stale_flag) ?
                           ufp_pkg::STALE_VALUE : stored_distances[j];
    end else begin : g_unused
      assign dist_out[j] = ufp_pkg::STALE_VALUE;
    end
  end

  assign res_valid      = go && emit;
  assign res.status     = status;
  assign res.distance_0 = dist_out[0];
  assign res.distance_1 = dist_out[1];
  assign res.distance_2 = dist_out[2];
  assign res.distance_3 = dist_out[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= ufp_pkg::POS_HUNT;
      running_sum    <= '0;
      frame_age      <= 16'd500;
      byte_gap       <= '0;
      stale_flag     <= 1'b1;
      for (int j = 0; j < ufp_pkg::SENSOR_COUNT; j++) begin
        stored_distances[j] <= ufp_pkg::STALE_VALUE;
      end
    end else if (go) begin
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
      frame_age      <= frame_age_next;
      byte_gap       <= byte_gap_next;
      stale_flag     <= stale_flag_next;
      if (load_dist) begin
        for (int j = 0; j < ufp_pkg::SENSOR_COUNT; j++) begin
          stored_distances[j] <= new_dist[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && asm_we) begin
      assembly_bytes[asm_idx] <= item.rx_byte;
    end
  end

`include "ultrasonic_frame_parser_unit_macros.svh"

  `UFP_ASSERT_NEXT(a_good_clears_age, res_valid && res.status == ufp_pkg::ST_GOOD, !stale_flag && frame_age == 16'd0, "good frame did not restart the age")
  `UFP_ASSERT_NEXT(a_short_rehunts, res_valid && res.status == ufp_pkg::ST_SHORT, frame_position == ufp_pkg::POS_HUNT && byte_gap == 8'd0, "short frame left the frame open")
  `UFP_ASSERT_SAME(a_stale_once, res_valid && res.status == ufp_pkg::ST_STALE, !stale_flag && frame_position == frame_position_next, "stale result while already stale")

endmodule

// ===== rtl/core/ultrasonic_frame_parser_unit.sv =====
// ============================================================================
// Ultrasonic frame parser unit
// Parses start-byte framed distance records with an 8-bit sum checksum,
// times byte gaps and data age from millisecond ticks, and reports results.
//
//   Channel  Signals                            Direction  Transaction
//   item     item_valid, item_stall, item       in         one byte or tick
//   result   result_valid, result_stall, result out        one status record
//   cfg      cfg_we, cfg_index, cfg_data        in         one register write
//
// One item is accepted per cycle unless item_stall is high; the item is held
// in the input register and its result in the result register; the frame
// engine between them does one compare, add and update per item.
// Reset is synchronous; the frame engine returns to hunting and stale.
// A stalled result holds the engine and raises item_stall only when the
// input register is also full.
// ============================================================================
module ultrasonic_frame_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ufp_pkg::ufp_in_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ufp_pkg::ufp_out_t               result,
  input  logic                            cfg_we,
  input  logic [ufp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ufp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              s1_valid;
  ufp_pkg::ufp_in_t  s1_item;
  logic              go;
  logic              blocked;
  logic              accept;
  logic              res_valid;
  ufp_pkg::ufp_out_t res;
  ufp_pkg::ufp_cfg_t cfg;

  assign blocked    = result_valid && result_stall;
  assign go         = s1_valid && !blocked;
  assign item_stall = s1_valid && blocked;
  assign accept     = item_valid && !item_stall;

  ufp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ufp_frame_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= res_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      result <= res;
    end
  end

endmodule
